FILE: rtl/position_pid_antiwindup_core_defines.svh
// ----------------------------------------------------------------------------
// position_pid_antiwindup_core_defines.svh
// assertion macros shared by the checker of the position pid core
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_ANTIWINDUP_CORE_DEFINES_SVH
`define POSITION_PID_ANTIWINDUP_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIDAW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIDAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// types and constants of the position pid core with integral clamp
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

    // field widths
    localparam int REF_RAW_W  = 20;
    localparam int ANGLE_W    = 16;
    localparam int REF_W      = 17;
    localparam int ERR_W      = 18;
    localparam int INTEG_W    = 16;
    localparam int DERIV_W    = 19;
    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 15;
    localparam int CMD_W      = 16;
    localparam int RAW_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // divide by ten through a reciprocal, exact for magnitudes below 2^22
    localparam int DIV10_SHIFT = 23;
    localparam int DIV10_PROD_W = 2 * REF_RAW_W;
    localparam logic [REF_RAW_W-1:0] DIV10_RECIP = 20'd838861;

    // product and accumulator widths
    localparam int P_ERR_W   = GAIN_W + ERR_W;
    localparam int P_INT_W   = GAIN_W + INTEG_W;
    localparam int P_DER_W   = GAIN_W + DERIV_W;
    localparam int SUM_W     = P_DER_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int CTRL_W    = SUM_W - FRAC_BITS;

    localparam logic [SUM_W-1:0] FRAC_BIAS = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic [RAW_W-1:0] RAW_MAX   = 32'h7fff_ffff;
    localparam logic [RAW_W-1:0] RAW_MIN   = 32'h8000_0000;

    // reset values of the limit registers
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST   = 15'd500;
    localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST = 15'd300;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN        = 3'd0,
        CFG_KI_GAIN        = 3'd1,
        CFG_KD_GAIN        = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_CURRENT_LIMIT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } gains_t;

    // one control tick as it enters
    typedef struct packed {
        logic                        tracking;
        logic                        run;
        logic signed [REF_RAW_W-1:0] reference_raw;
        logic signed [ANGLE_W-1:0]   measured_angle;
        logic                        record_request;
    } in_item_t;

    // tick after reference scaling and error
    typedef struct packed {
        logic                      tracking;
        logic                      run;
        logic signed [ERR_W-1:0]   err;
        logic signed [REF_W-1:0]   ref_value;
        logic signed [ANGLE_W-1:0] meas;
        logic                      rec;
    } err_item_t;

    // tick with the three pid terms
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [REF_W-1:0]   ref_value;
        logic signed [ANGLE_W-1:0] meas;
        logic                      rec;
    } pid_item_t;

    // one result
    typedef struct packed {
        logic signed [CMD_W-1:0]   current_command;
        logic signed [REF_W-1:0]   reference_value;
        logic signed [ANGLE_W-1:0] sensor_value;
        logic signed [RAW_W-1:0]   control_raw;
        logic                      record_flag;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/position_pid_antiwindup_core.sv
// ----------------------------------------------------------------------------
// position_pid_antiwindup_core
// position pid controller with clamped integral, one control tick per transfer
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one control tick per transfer; m_* returns one result for
//   each tick with tracking and run both set. A tick with tracking clear
//   is dropped; tracking set with run clear clears the integral and the
//   previous error and returns nothing.
//   cfg_we/cfg_index/cfg_wdata write the gains and limits; write only while
//   no tick is in flight.
//   Pipeline: a result reaches m_* through the input register, two
//   divide-by-ten stages, integrator stage, product stage, sum stage and
//   result register.
//   Throughput: one tick per cycle when not stalled; each stage holds one tick
//   and the integral/previous-error registers update in the integrator stage.
//   Reset: loop state and gains clear, limits load 500 and 300, all stages
//   empty.
//   Stall: while m_tready is low the result holds; earlier stages keep
//   taking ticks until they fill, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module position_pid_antiwindup_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pidaw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // tick input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [19:0] reference_raw, [35:20] measured_angle, [39:36] zero
    input  wire logic [39:0]                         s_tdata,
    // [0] tracking, [1] run, [2] record_request
    input  wire logic [2:0]                          s_tuser,
    // result output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [15:0] current_command, [32:16] reference_value, [48:33] sensor_value,
    // [80:49] control_raw, [87:81] zero
    output logic [87:0]                              m_tdata,
    // [0] record_flag
    output logic [0:0]                               m_tuser
);

    // configuration registers
    pidaw_pkg::gains_t                    gains_reg;
    logic [pidaw_pkg::LIMIT_W-1:0]        integ_limit_reg;
    logic [pidaw_pkg::LIMIT_W-1:0]        current_limit_reg;

    // input register
    logic                                 in_valid_reg;
    pidaw_pkg::in_item_t                  in_item_reg;
    pidaw_pkg::in_item_t                  in_item_next;

    logic                                 div_in_ready;
    logic                                 div_out_valid;
    pidaw_pkg::err_item_t                 div_out_item;
    logic                                 int_in_ready;
    logic                                 int_out_valid;
    pidaw_pkg::pid_item_t                 int_out_item;
    logic                                 mac_in_ready;
    pidaw_pkg::result_t                   result;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg         <= '0;
            integ_limit_reg   <= pidaw_pkg::INTEG_LIMIT_RST;
            current_limit_reg <= pidaw_pkg::CURRENT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (pidaw_pkg::cfg_index_t'(cfg_index))
                pidaw_pkg::CFG_KP_GAIN:        gains_reg.kp <= signed'(cfg_wdata);
                pidaw_pkg::CFG_KI_GAIN:        gains_reg.ki <= signed'(cfg_wdata);
                pidaw_pkg::CFG_KD_GAIN:        gains_reg.kd <= signed'(cfg_wdata);
                pidaw_pkg::CFG_INTEGRAL_LIMIT:
                    integ_limit_reg <= cfg_wdata[pidaw_pkg::LIMIT_W-1:0];
                pidaw_pkg::CFG_CURRENT_LIMIT:
                    current_limit_reg <= cfg_wdata[pidaw_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input transfer
    always_comb
    begin
        in_item_next.tracking       = s_tuser[0];
        in_item_next.run            = s_tuser[1];
        in_item_next.record_request = s_tuser[2];
        in_item_next.reference_raw  = signed'(s_tdata[19:0]);
        in_item_next.measured_angle = signed'(s_tdata[35:20]);
    end

    assign s_tready = !in_valid_reg || div_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_next;
        end
    end

    // reference scaling and error
    pidaw_refdiv u_refdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (div_in_ready),
        .in_item   (in_item_reg),
        .out_valid (div_out_valid),
        .out_ready (int_in_ready),
        .out_item  (div_out_item)
    );

    // integral, derivative and loop state
    pidaw_integ u_integ (
        .clk            (clk),
        .rst_n          (rst_n),
        .integral_limit (integ_limit_reg),
        .in_valid       (div_out_valid),
        .in_ready       (int_in_ready),
        .in_item        (div_out_item),
        .out_valid      (int_out_valid),
        .out_ready      (mac_in_ready),
        .out_item       (int_out_item)
    );

    // products, sum and output clamp
    pidaw_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .gains         (gains_reg),
        .current_limit (current_limit_reg),
        .in_valid      (int_out_valid),
        .in_ready      (mac_in_ready),
        .in_item       (int_out_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (result)
    );

    // pack the result transfer
    assign m_tdata = {7'b0, result.control_raw, result.sensor_value,
                      result.reference_value, result.current_command};
    assign m_tuser = result.record_flag;

endmodule

`default_nettype wire

FILE: rtl/pidaw_refdiv.sv
// ----------------------------------------------------------------------------
// pidaw_refdiv
// two stages: reference divided by ten toward zero, then the tracking error
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_refdiv (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pidaw_pkg::in_item_t  in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pidaw_pkg::err_item_t      out_item
);

    // stage a: magnitude times reciprocal
    logic                                   a_valid_reg;
    logic                                   a_ready;
    logic [pidaw_pkg::DIV10_PROD_W-1:0]     a_prod_reg;
    logic [pidaw_pkg::DIV10_PROD_W-1:0]     a_prod_next;
    logic                                   a_neg_reg;
    logic signed [pidaw_pkg::ANGLE_W-1:0]   a_meas_reg;
    logic                                   a_trk_reg;
    logic                                   a_run_reg;
    logic                                   a_rec_reg;
    logic [pidaw_pkg::REF_RAW_W-1:0]        raw_u;
    logic [pidaw_pkg::REF_RAW_W-1:0]        a_mag;

    // stage b: signed quotient and error
    logic                                   b_valid_reg;
    logic                                   b_ready;
    pidaw_pkg::err_item_t                   b_item_reg;
    pidaw_pkg::err_item_t                   b_item_next;
    logic [pidaw_pkg::REF_W-1:0]            quot;
    logic signed [pidaw_pkg::REF_W-1:0]     ref_s;

    // stage handshakes
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // absolute value and reciprocal multiply
    always_comb
    begin
        raw_u       = pidaw_pkg::REF_RAW_W'(unsigned'(in_item.reference_raw));
        a_mag       = raw_u[pidaw_pkg::REF_RAW_W-1] ? (~raw_u + 1'b1) : raw_u;
        a_prod_next = pidaw_pkg::DIV10_PROD_W'(a_mag)
                    * pidaw_pkg::DIV10_PROD_W'(pidaw_pkg::DIV10_RECIP);
    end

    // apply sign, subtract the measured angle
    always_comb
    begin
        quot  = a_prod_reg[pidaw_pkg::DIV10_SHIFT +: pidaw_pkg::REF_W];
        ref_s = a_neg_reg ? -signed'(quot) : signed'(quot);
        b_item_next.tracking  = a_trk_reg;
        b_item_next.run       = a_run_reg;
        b_item_next.ref_value = ref_s;
        b_item_next.meas      = a_meas_reg;
        b_item_next.rec       = a_rec_reg;
        b_item_next.err       = pidaw_pkg::ERR_W'(ref_s) - pidaw_pkg::ERR_W'(a_meas_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_prod_reg <= a_prod_next;
            a_neg_reg  <= in_item.reference_raw[pidaw_pkg::REF_RAW_W-1];
            a_meas_reg <= in_item.measured_angle;
            a_trk_reg  <= in_item.tracking;
            a_run_reg  <= in_item.run;
            a_rec_reg  <= in_item.record_request;
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

`default_nettype wire

FILE: rtl/pidaw_integ.sv
// ----------------------------------------------------------------------------
// pidaw_integ
// integral with clamp, derivative, and the two state registers of the loop
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_integ (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [pidaw_pkg::LIMIT_W-1:0]     integral_limit,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire pidaw_pkg::err_item_t              in_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output pidaw_pkg::pid_item_t                   out_item
);

    logic signed [pidaw_pkg::INTEG_W-1:0] integral_reg;
    logic signed [pidaw_pkg::INTEG_W-1:0] integral_next;
    logic signed [pidaw_pkg::ERR_W-1:0]   prev_err_reg;
    logic signed [pidaw_pkg::ERR_W-1:0]   prev_err_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    pidaw_pkg::pid_item_t                 out_item_reg;
    pidaw_pkg::pid_item_t                 out_item_next;

    logic                                 fire;
    logic                                 active;
    logic signed [pidaw_pkg::ERR_W-1:0]   sum;
    logic signed [pidaw_pkg::ERR_W-1:0]   lim;
    logic signed [pidaw_pkg::ERR_W-1:0]   clamped;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign active   = in_item.tracking && in_item.run;

    // accumulate, clamp, differentiate
    always_comb
    begin
        sum = pidaw_pkg::ERR_W'(integral_reg) + in_item.err;
        lim = signed'(pidaw_pkg::ERR_W'(integral_limit));
        if (sum > lim)
        begin
            clamped = lim;
        end
        else if (sum < -lim)
        begin
            clamped = -lim;
        end
        else
        begin
            clamped = sum;
        end

        out_item_next.err       = in_item.err;
        out_item_next.integ     = pidaw_pkg::INTEG_W'(clamped);
        out_item_next.deriv     = pidaw_pkg::DERIV_W'(in_item.err)
                                - pidaw_pkg::DERIV_W'(prev_err_reg);
        out_item_next.ref_value = in_item.ref_value;
        out_item_next.meas      = in_item.meas;
        out_item_next.rec       = in_item.rec;
    end

    // state update: ignored tick holds, stopped run clears
    always_comb
    begin
        integral_next  = integral_reg;
        prev_err_next  = prev_err_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            out_valid_next = fire && active;
        end
        if (fire && in_item.tracking)
        begin
            if (in_item.run)
            begin
                integral_next = out_item_next.integ;
                prev_err_next = in_item.err;
            end
            else
            begin
                integral_next = '0;
                prev_err_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            integral_reg  <= integral_next;
            prev_err_reg  <= prev_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && active)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: rtl/pidaw_mac.sv
// ----------------------------------------------------------------------------
// pidaw_mac
// gain products, q36.16 sum, truncation, saturation and current clamp
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_mac (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pidaw_pkg::gains_t                 gains,
    input  wire logic [pidaw_pkg::LIMIT_W-1:0]     current_limit,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire pidaw_pkg::pid_item_t              in_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output pidaw_pkg::result_t                     out_result
);

    // stage p: three products
    logic                                  p_valid_reg;
    logic                                  p_ready;
    logic signed [pidaw_pkg::P_ERR_W-1:0]  p_err_reg;
    logic signed [pidaw_pkg::P_INT_W-1:0]  p_int_reg;
    logic signed [pidaw_pkg::P_DER_W-1:0]  p_der_reg;
    logic signed [pidaw_pkg::REF_W-1:0]    p_ref_reg;
    logic signed [pidaw_pkg::ANGLE_W-1:0]  p_meas_reg;
    logic                                  p_rec_reg;

    // stage s: sum
    logic                                  s_valid_reg;
    logic                                  s_ready;
    logic signed [pidaw_pkg::SUM_W-1:0]    s_sum_reg;
    logic signed [pidaw_pkg::SUM_W-1:0]    s_sum_next;
    logic signed [pidaw_pkg::REF_W-1:0]    s_ref_reg;
    logic signed [pidaw_pkg::ANGLE_W-1:0]  s_meas_reg;
    logic                                  s_rec_reg;

    // stage o: result register
    logic                                  o_valid_reg;
    logic                                  o_ready;
    pidaw_pkg::result_t                    o_result_reg;
    pidaw_pkg::result_t                    o_result_next;

    logic [pidaw_pkg::SUM_W-1:0]           biased;
    logic signed [pidaw_pkg::CTRL_W-1:0]   ctrl;
    logic signed [pidaw_pkg::CTRL_W-1:0]   lim;
    logic                                  fits;
    logic signed [pidaw_pkg::CTRL_W-1:0]   cmd_wide;

    assign o_ready  = !o_valid_reg || out_ready;
    assign s_ready  = !s_valid_reg || o_ready;
    assign p_ready  = !p_valid_reg || s_ready;
    assign in_ready = p_ready;

    // exact sum of the products
    assign s_sum_next = pidaw_pkg::SUM_W'(p_err_reg) + pidaw_pkg::SUM_W'(p_int_reg)
                      + pidaw_pkg::SUM_W'(p_der_reg);

    // truncate toward zero, saturate raw, clamp command
    always_comb
    begin
        biased = unsigned'(s_sum_reg)
               + (s_sum_reg[pidaw_pkg::SUM_W-1] ? pidaw_pkg::FRAC_BIAS : '0);
        ctrl   = signed'(biased[pidaw_pkg::SUM_W-1:pidaw_pkg::FRAC_BITS]);
        fits   = (&ctrl[pidaw_pkg::CTRL_W-1:pidaw_pkg::RAW_W-1])
              || !(|ctrl[pidaw_pkg::CTRL_W-1:pidaw_pkg::RAW_W-1]);
        lim    = signed'(pidaw_pkg::CTRL_W'(current_limit));
        if (ctrl > lim)
        begin
            cmd_wide = lim;
        end
        else if (ctrl < -lim)
        begin
            cmd_wide = -lim;
        end
        else
        begin
            cmd_wide = ctrl;
        end

        o_result_next.current_command = pidaw_pkg::CMD_W'(cmd_wide);
        o_result_next.reference_value = s_ref_reg;
        o_result_next.sensor_value    = s_meas_reg;
        o_result_next.record_flag     = s_rec_reg;
        if (fits)
        begin
            o_result_next.control_raw = pidaw_pkg::RAW_W'(ctrl);
        end
        else if (ctrl[pidaw_pkg::CTRL_W-1])
        begin
            o_result_next.control_raw = signed'(pidaw_pkg::RAW_MIN);
        end
        else
        begin
            o_result_next.control_raw = signed'(pidaw_pkg::RAW_MAX);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            p_err_reg  <= gains.kp * in_item.err;
            p_int_reg  <= gains.ki * in_item.integ;
            p_der_reg  <= gains.kd * in_item.deriv;
            p_ref_reg  <= in_item.ref_value;
            p_meas_reg <= in_item.meas;
            p_rec_reg  <= in_item.rec;
        end
        if (s_ready && p_valid_reg)
        begin
            s_sum_reg  <= s_sum_next;
            s_ref_reg  <= p_ref_reg;
            s_meas_reg <= p_meas_reg;
            s_rec_reg  <= p_rec_reg;
        end
        if (o_ready && s_valid_reg)
        begin
            o_result_reg <= o_result_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_result = o_result_reg;

endmodule

`default_nettype wire

FILE: rtl/pidaw_checker.sv
// ----------------------------------------------------------------------------
// pidaw_checker
// port-level checks of the position pid core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "position_pid_antiwindup_core_defines.svh"

module pidaw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    logic [88:0]        out_word;
    logic               stalled;
    logic signed [16:0] ref_val;
    logic               ref_ok;
    logic               ctrl_neg;
    logic               cmd_neg;
    logic               cmd_nonpos;

    // result fields as seen on the port
    assign out_word   = {m_tuser, m_tdata};
    assign stalled    = m_tvalid && !m_tready;
    assign ref_val    = signed'(m_tdata[32:16]);
    assign ref_ok     = (ref_val <= 17'sd52428) && (ref_val >= -17'sd52428);
    assign ctrl_neg   = m_tdata[80];
    assign cmd_neg    = m_tdata[15];
    assign cmd_nonpos = m_tdata[15] || (m_tdata[15:0] == 16'd0);

    // stalled result holds
    `PIDAW_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(out_word), "result moved in stall")

    // scaled reference stays inside the divided input range
    `PIDAW_ASSERT_IMPL(a_ref_range, m_tvalid, ref_ok, "reference out of range")

    // non-negative control never gives a negative command
    `PIDAW_ASSERT_IMPL(a_cmd_sign_pos, m_tvalid && !ctrl_neg, !cmd_neg, "command sign wrong")

    // negative control never gives a positive command
    `PIDAW_ASSERT_IMPL(a_cmd_sign_neg, m_tvalid && ctrl_neg, cmd_nonpos, "command sign wrong")

endmodule

bind position_pid_antiwindup_core pidaw_checker u_pidaw_checker (.*);

`default_nettype wire
